### rtl/ghb_delta_correlation_prefetcher_defines.svh
// Assertion macros shared by the checker of the delta-correlation prefetcher.
// Depends on nothing; included by files that assert.
`ifndef GHB_DELTA_CORRELATION_PREFETCHER_DEFINES_SVH
`define GHB_DELTA_CORRELATION_PREFETCHER_DEFINES_SVH

// Same-cycle implication, off during reset
`define GDCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define GDCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gdcp_pkg.sv
// Types and constants of the delta-correlation prefetcher.
// Depends on nothing; used by the top, front and back modules.
`timescale 1ns / 1ps
`default_nettype none
package gdcp_pkg;
    localparam int ADDR_W  = 64;
    localparam int CHUNK_W = 16;
    localparam int STEPS_W = 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_LINK,
        S_WALK,
        S_FIN
    } t_bstate;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_MATCH1,
        PH_MATCH2
    } t_phase;

    typedef enum logic [1:0] {
        F_MUL,
        F_SUB,
        F_FIX
    } t_fstep;
endpackage
`default_nettype wire

### rtl/ghb_delta_correlation_prefetcher.sv
// Top level of the delta-correlation prefetcher with a global history buffer.
// Depends on gdcp_pkg, gdcp_front, gdcp_queue and gdcp_back.
//
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------------------
//  access in | i_push / o_full  | i_access_address, i_instr_address, i_was_hit
//  result out| o_empty / i_pop  | o_base_address, o_prefetch_address
//
// A hit does not stall the input. A miss holds it while its slot is reduced
// (four 16-bit chunks, each by multiply, subtract and fix steps) and until the
// queue takes it. The back then passes its head, link, walk and finish states,
// one chain entry per cycle over the history read port in the walk, the entry
// that ends it included. After reset the back clears both memories, over
// max(HISTORY_DEPTH, INDEX_DEPTH) addresses; the front still takes items into
// the two-entry queue meanwhile. A waiting result stalls only the back.
`timescale 1ns / 1ps
`default_nettype none
module ghb_delta_correlation_prefetcher
    import gdcp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 1024,
    parameter int INDEX_DEPTH   = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [ADDR_W-1:0] i_access_address,
    input  wire logic [ADDR_W-1:0] i_instr_address,
    input  wire logic              i_was_hit,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [ADDR_W-1:0]      o_base_address,
    output logic [ADDR_W-1:0]      o_prefetch_address
);
    localparam int IW = $clog2(INDEX_DEPTH);
    localparam int JW = 2 * ADDR_W + IW;

    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;
    logic [JW-1:0] w_q_in, w_q_out;

    gdcp_front #(.INDEX_DEPTH(INDEX_DEPTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_access_address(i_access_address),
        .i_instr_address (i_instr_address),
        .i_was_hit       (i_was_hit),
        .o_job_push      (w_q_push),
        .i_job_full      (w_q_full),
        .o_job_data      (w_q_in)
    );

    gdcp_queue #(.W(JW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .o_full (w_q_full),
        .i_data (w_q_in),
        .i_pop  (w_q_pop),
        .o_empty(w_q_empty),
        .o_data (w_q_out)
    );

    gdcp_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .INDEX_DEPTH  (INDEX_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (!w_q_empty),
        .o_job_pop         (w_q_pop),
        .i_job_addr        (w_q_out[JW-1 -: ADDR_W]),
        .i_job_ip          (w_q_out[IW +: ADDR_W]),
        .i_job_slot        (w_q_out[IW-1:0]),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_base_address    (o_base_address),
        .o_prefetch_address(o_prefetch_address)
    );
endmodule
`default_nettype wire

### rtl/gdcp_front.sv
// Front part: accepts accesses, drops hits, reduces the instruction address
// to an index slot 16 bits at a time. Depends on gdcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdcp_front
    import gdcp_pkg::*;
#(
    parameter int INDEX_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic [ADDR_W-1:0]               i_access_address,
    input  wire logic [ADDR_W-1:0]               i_instr_address,
    input  wire logic                            i_was_hit,
    output logic                                 o_job_push,
    input  wire logic                            i_job_full,
    output logic [2*ADDR_W+$clog2(INDEX_DEPTH)-1:0] o_job_data
);
    localparam int IW = $clog2(INDEX_DEPTH);
    localparam logic [2*CHUNK_W-1:0] RECIP =
        (2*CHUNK_W)'((64'd1 << (2*CHUNK_W)) / 64'(INDEX_DEPTH));

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [STEPS_W-1:0]   r_chunk, n_chunk;
    t_fstep               r_fstep, n_fstep;
    logic [ADDR_W-1:0]    r_sh, n_sh;
    logic [IW-1:0]        r_rem, n_rem;
    logic [2*CHUNK_W-1:0] r_q, n_q;
    logic [IW:0]          r_t, n_t;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [ADDR_W-1:0]    r_ip, n_ip;
    logic [2*CHUNK_W-1:0] w_v;
    logic [4*CHUNK_W-1:0] w_prod;
    logic [3*CHUNK_W-1:0] w_t;

    assign o_full     = r_busy;
    assign o_job_push = r_done;
    assign o_job_data = {r_addr, r_ip, r_rem};

    // Partial remainder followed by the next chunk, its reciprocal estimate
    // of the quotient (exact or one low) and the remainder left by it
    assign w_v    = {CHUNK_W'(r_rem), r_sh[ADDR_W-1 -: CHUNK_W]};
    assign w_prod = (4*CHUNK_W)'(w_v) * (4*CHUNK_W)'(RECIP);
    assign w_t    = (3*CHUNK_W)'(w_v) - (3*CHUNK_W)'(r_q) * (3*CHUNK_W)'(INDEX_DEPTH);

    // Reduce the instruction address modulo the index depth, chunk by chunk
    always_comb begin
        n_busy  = r_busy;
        n_done  = r_done;
        n_chunk = r_chunk;
        n_fstep = r_fstep;
        n_sh    = r_sh;
        n_rem   = r_rem;
        n_q     = r_q;
        n_t     = r_t;
        n_addr  = r_addr;
        n_ip    = r_ip;
        if (!r_busy) begin
            if (i_push && !i_was_hit) begin
                n_busy  = 1'b1;
                n_done  = 1'b0;
                n_chunk = '0;
                n_fstep = F_MUL;
                n_rem   = '0;
                n_sh    = i_instr_address;
                n_addr  = i_access_address;
                n_ip    = i_instr_address;
            end
        end else if (!r_done) begin
            unique case (r_fstep)
                F_MUL: begin
                    n_q     = w_prod[4*CHUNK_W-1 -: 2*CHUNK_W];
                    n_fstep = F_SUB;
                end
                F_SUB: begin
                    n_t     = w_t[IW:0];
                    n_fstep = F_FIX;
                end
                F_FIX: begin
                    if (r_t >= (IW+1)'(INDEX_DEPTH)) begin
                        n_rem = IW'(r_t - (IW+1)'(INDEX_DEPTH));
                    end else begin
                        n_rem = r_t[IW-1:0];
                    end
                    n_sh    = r_sh << CHUNK_W;
                    n_chunk = r_chunk + 1'b1;
                    n_fstep = F_MUL;
                    if (r_chunk == '1) begin
                        n_done = 1'b1;
                    end
                end
                default: n_fstep = F_MUL;
            endcase
        end else if (!i_job_full) begin
            n_busy = 1'b0;
            n_done = 1'b0;
        end
    end

    // Hold control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_chunk <= '0;
            r_fstep <= F_MUL;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_chunk <= n_chunk;
            r_fstep <= n_fstep;
        end
        r_sh   <= n_sh;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_t    <= n_t;
        r_addr <= n_addr;
        r_ip   <= n_ip;
    end
endmodule
`default_nettype wire

### rtl/gdcp_queue.sv
// Two-entry queue between the front and back parts.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module gdcp_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wr] <= i_data;
    end
endmodule
`default_nettype wire

### rtl/gdcp_back.sv
// Back part: history and index memories, link and chain walk, result register.
// Depends on gdcp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdcp_back
    import gdcp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 1024,
    parameter int INDEX_DEPTH   = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_job_valid,
    output logic                                o_job_pop,
    input  wire logic [ADDR_W-1:0]              i_job_addr,
    input  wire logic [ADDR_W-1:0]              i_job_ip,
    input  wire logic [$clog2(INDEX_DEPTH)-1:0] i_job_slot,
    output logic                                o_empty,
    input  wire logic                           i_pop,
    output logic [ADDR_W-1:0]                   o_base_address,
    output logic [ADDR_W-1:0]                   o_prefetch_address
);
    localparam int HW   = $clog2(HISTORY_DEPTH);
    localparam int IW   = $clog2(INDEX_DEPTH);
    localparam int MAXD = (HISTORY_DEPTH > INDEX_DEPTH) ? HISTORY_DEPTH : INDEX_DEPTH;
    localparam int CLW  = $clog2(MAXD);
    localparam int CNTW = $clog2(HISTORY_DEPTH + 1);

    // Memories
    logic [ADDR_W-1:0] m_addr  [HISTORY_DEPTH];
    logic [ADDR_W-1:0] m_instr [HISTORY_DEPTH];
    logic [HW-1:0]     m_link  [HISTORY_DEPTH];
    logic [HW-1:0]     m_head  [INDEX_DEPTH];

    logic [ADDR_W-1:0] r_q_addr, r_q_instr;
    logic [HW-1:0]     r_q_link, r_q_head;

    logic              h_we, x_we;
    logic [HW-1:0]     h_wa, h_ra, h_wd_link, x_wd;
    logic [ADDR_W-1:0] h_wd_addr, h_wd_instr;
    logic [IW-1:0]     x_wa, x_ra;

    t_bstate           r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [CLW-1:0]    r_clr, n_clr;
    logic [ADDR_W-1:0] r_addr, n_addr, r_ip, n_ip;
    logic [IW-1:0]     r_slot, n_slot;
    logic [HW-1:0]     r_wp, n_wp, r_e, n_e;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_first, n_first, r_second, n_second, r_prev, n_prev;
    logic              r_found, n_found;
    logic              r_ovalid, n_ovalid;
    logic [ADDR_W-1:0] r_base, n_base, r_pf, n_pf;

    logic              w_walk_ok;
    logic [ADDR_W-1:0] w_d, w_hi, w_lo;
    logic [HW-1:0]     w_link;

    assign o_empty            = !r_ovalid;
    assign o_base_address     = r_base;
    assign o_prefetch_address = r_pf;

    // Write and read the memories
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            m_addr[h_wa]  <= h_wd_addr;
            m_instr[h_wa] <= h_wd_instr;
            m_link[h_wa]  <= h_wd_link;
        end
        r_q_addr  <= m_addr[h_ra];
        r_q_instr <= m_instr[h_ra];
        r_q_link  <= m_link[h_ra];
        if (x_we) m_head[x_wa] <= x_wd;
        r_q_head <= m_head[x_ra];
    end

    assign w_walk_ok = (r_q_link != r_e) && (r_q_instr == r_ip)
                       && (r_cnt < CNTW'(HISTORY_DEPTH));
    assign w_d       = r_prev - r_q_addr;
    assign w_link    = (r_q_instr == r_ip) ? r_q_head : r_wp;
    assign w_hi      = ($signed(r_first) >= $signed(r_second)) ? r_first : r_second;
    assign w_lo      = ($signed(r_first) >= $signed(r_second)) ? r_second : r_first;

    // Sequence clear, link, walk and result
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_clr    = r_clr;
        n_addr   = r_addr;
        n_ip     = r_ip;
        n_slot   = r_slot;
        n_wp     = r_wp;
        n_e      = r_e;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_second = r_second;
        n_prev   = r_prev;
        n_found  = r_found;
        n_ovalid = r_ovalid && !i_pop;
        n_base   = r_base;
        n_pf     = r_pf;
        o_job_pop  = 1'b0;
        h_we       = 1'b0;
        h_wa       = r_wp;
        h_wd_addr  = r_addr;
        h_wd_instr = r_ip;
        h_wd_link  = w_link;
        h_ra       = r_e;
        x_we       = 1'b0;
        x_wa       = r_slot;
        x_wd       = r_wp;
        x_ra       = r_slot;
        unique case (r_state)
            S_CLEAR: begin
                h_we       = ({1'b0, r_clr} < (CLW+1)'(HISTORY_DEPTH));
                h_wa       = r_clr[HW-1:0];
                h_wd_addr  = '0;
                h_wd_instr = '0;
                h_wd_link  = '0;
                x_we       = ({1'b0, r_clr} < (CLW+1)'(INDEX_DEPTH));
                x_wa       = r_clr[IW-1:0];
                x_wd       = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == CLW'(MAXD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                x_ra = i_job_slot;
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_addr    = i_job_addr;
                    n_ip      = i_job_ip;
                    n_slot    = i_job_slot;
                    n_first   = i_job_addr;
                    n_cnt     = '0;
                    n_phase   = PH_FIRST;
                    n_found   = 1'b0;
                    n_state   = S_HEAD;
                end
            end
            S_HEAD: begin
                h_ra    = r_q_head;
                n_state = S_LINK;
            end
            S_LINK: begin
                h_we    = 1'b1;
                x_we    = 1'b1;
                h_ra    = w_link;
                n_e     = w_link;
                n_state = (w_link == r_wp) ? S_FIN : S_WALK;
            end
            S_WALK: begin
                if (!w_walk_ok) begin
                    n_state = S_FIN;
                end else begin
                    h_ra = r_q_link;
                    n_e  = r_q_link;
                    case (r_phase)
                        PH_FIRST: begin
                            n_first  = r_first - r_q_addr;
                            n_second = r_q_addr;
                            n_phase  = PH_SECOND;
                        end
                        PH_SECOND: begin
                            n_second = r_second - r_q_addr;
                            n_prev   = r_q_addr;
                            n_phase  = PH_MATCH1;
                        end
                        PH_MATCH1: begin
                            n_cnt  = r_cnt + 1'b1;
                            n_prev = r_q_addr;
                            if (w_d == r_first) n_phase = PH_MATCH2;
                        end
                        default: begin
                            if (w_d == r_second) begin
                                n_found = 1'b1;
                                n_state = S_FIN;
                            end else begin
                                n_cnt   = r_cnt + 1'b1;
                                n_prev  = r_q_addr;
                                n_phase = (w_d == r_first) ? PH_MATCH2 : PH_MATCH1;
                            end
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (!r_found || !r_ovalid || i_pop) begin
                    if (r_found) begin
                        n_ovalid = 1'b1;
                        n_base   = w_lo[ADDR_W-1] ? r_addr + w_lo : r_addr;
                        n_pf     = (w_hi != '0 && !w_hi[ADDR_W-1]) ? r_addr + w_hi : r_addr;
                    end
                    n_wp    = (r_wp == HW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_wp     <= n_wp;
            r_ovalid <= n_ovalid;
        end
        r_phase  <= n_phase;
        r_addr   <= n_addr;
        r_ip     <= n_ip;
        r_slot   <= n_slot;
        r_e      <= n_e;
        r_cnt    <= n_cnt;
        r_first  <= n_first;
        r_second <= n_second;
        r_prev   <= n_prev;
        r_found  <= n_found;
        r_base   <= n_base;
        r_pf     <= n_pf;
    end
endmodule
`default_nettype wire

### rtl/gdcp_checker.sv
// Port-level checks of the delta-correlation prefetcher, bound to its top.
// Depends on the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "ghb_delta_correlation_prefetcher_defines.svh"
module gdcp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_push,
    input wire logic        o_full,
    input wire logic        i_was_hit,
    input wire logic        o_empty,
    input wire logic        i_pop,
    input wire logic [63:0] o_base_address,
    input wire logic [63:0] o_prefetch_address
);
    // Results wait unchanged until taken
    `GDCP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_base_address) && $stable(o_prefetch_address), "result changed before pop")
    // No result right after reset
    `GDCP_ASSERT_IMPLY(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n), o_empty, "result after reset")
    // A miss keeps the input busy while its slot is formed
    `GDCP_ASSERT_NEXT(a_miss_busy, i_clk, i_rst_n, i_push && !o_full && !i_was_hit, o_full, "miss not held")
    // A hit leaves the input free
    `GDCP_ASSERT_NEXT(a_hit_free, i_clk, i_rst_n, i_push && !o_full && i_was_hit, !o_full, "hit stalled input")
endmodule

bind ghb_delta_correlation_prefetcher gdcp_checker u_gdcp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_push            (i_push),
    .o_full            (o_full),
    .i_was_hit         (i_was_hit),
    .o_empty           (o_empty),
    .i_pop             (i_pop),
    .o_base_address    (o_base_address),
    .o_prefetch_address(o_prefetch_address)
);
`default_nettype wire
